>>> rtl/tcql_pkg.sv
// Shared constants, types and register codes of the two-choice Q-learning trial block.
`timescale 1ns / 1ps
`default_nettype none
package tcql_pkg;

	localparam int FRAC_BITS = 14;
	localparam int TEMP_FRAC = 10;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int HALF      = 1 << (FRAC_BITS - 1);

	localparam int VAL_W   = FRAC_BITS + 1;
	localparam int ERR_W   = VAL_W + 1;
	localparam int RATE_W  = 15;
	localparam int TEMP_W  = 16;
	localparam int LIMIT_W = 16;
	localparam int MODE_W  = 3;

	localparam int MODE_ERR_RATE  = 0;
	localparam int MODE_GATE_RATE = 1;
	localparam int MODE_GATE_TEMP = 2;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int IN_BITS   = 4;
	localparam int S_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = 5 * VAL_W + 2 * ERR_W;
	localparam int M_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

	// Logistic argument step is 16 / entries; the index drops the value, temperature
	// and step fractions at once.
	localparam int IDX_SHIFT = FRAC_BITS + TEMP_FRAC + 4;

	localparam int LOGI_ENTRIES_DEF = 1024;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_RATE_BASE         = 3'd0,
		REG_RATE_ON_ERROR     = 3'd1,
		REG_RATE_LOW_CONFLICT = 3'd2,
		REG_TEMP_BASE         = 3'd3,
		REG_TEMP_LOW_CONFLICT = 3'd4,
		REG_FORGET_RATE       = 3'd5,
		REG_CONFLICT_LIMIT    = 3'd6,
		REG_MODE_BITS         = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [RATE_W-1:0]         rate_base;
		logic [RATE_W-1:0]         rate_on_error;
		logic [RATE_W-1:0]         rate_low_conflict;
		logic [TEMP_W-1:0]         temp_base;
		logic [TEMP_W-1:0]         temp_low_conflict;
		logic [RATE_W-1:0]         forget_rate;
		logic signed [LIMIT_W-1:0] conflict_limit;
		logic [MODE_W-1:0]         mode_bits;
	} cfg_t;

endpackage
`default_nettype wire

>>> rtl/tcql_cfg.sv
// Configuration register file of the two-choice Q-learning trial block.
`timescale 1ns / 1ps
`default_nettype none
module tcql_cfg
	import tcql_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_base         <= RATE_W'(4096);
			cfg_q.rate_on_error     <= RATE_W'(4096);
			cfg_q.rate_low_conflict <= RATE_W'(4096);
			cfg_q.temp_base         <= TEMP_W'(5120);
			cfg_q.temp_low_conflict <= TEMP_W'(5120);
			cfg_q.forget_rate       <= '0;
			cfg_q.conflict_limit    <= '0;
			cfg_q.mode_bits         <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_RATE_BASE:         cfg_q.rate_base         <= cfg_data[RATE_W-1:0];
				REG_RATE_ON_ERROR:     cfg_q.rate_on_error     <= cfg_data[RATE_W-1:0];
				REG_RATE_LOW_CONFLICT: cfg_q.rate_low_conflict <= cfg_data[RATE_W-1:0];
				REG_TEMP_BASE:         cfg_q.temp_base         <= cfg_data[TEMP_W-1:0];
				REG_TEMP_LOW_CONFLICT: cfg_q.temp_low_conflict <= cfg_data[TEMP_W-1:0];
				REG_FORGET_RATE:       cfg_q.forget_rate       <= cfg_data[RATE_W-1:0];
				REG_CONFLICT_LIMIT:    cfg_q.conflict_limit    <= $signed(cfg_data[LIMIT_W-1:0]);
				REG_MODE_BITS:         cfg_q.mode_bits         <= cfg_data[MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> rtl/tcql_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module tcql_mul
	import tcql_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic signed [MUL_A_W-1:0]  a,
	input  wire logic signed [MUL_B_W-1:0]  b,
	output logic signed [MUL_P_W-1:0]       p
);

	logic signed [MUL_P_W-1:0] prod;

	assign prod = MUL_P_W'(a) * MUL_P_W'(b);

	always_ff @(posedge clk) begin
		p <= prod;
	end

endmodule
`default_nettype wire

>>> rtl/tcql_logi_rom.sv
// Logistic function table with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module tcql_logi_rom
	import tcql_pkg::*;
#(
	parameter int unsigned ENTRIES = LOGI_ENTRIES_DEF
) (
	input  wire logic                       clk,
	input  wire logic [$clog2(ENTRIES)-1:0] addr,
	output logic [VAL_W-1:0]                data
);

	localparam int AW = $clog2(ENTRIES);
	localparam longint unsigned Q30 = 64'd1 << 30;

	typedef longint unsigned u64_t;
	typedef logic [VAL_W-1:0] logi_tab_t [ENTRIES];

	// Quotient of two constants by restoring long division, evaluated at elaboration.
	function automatic u64_t udiv(input u64_t num, input u64_t den);
		u64_t quo;
		u64_t rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// e^-f with f and the result in Q.30, by its series truncated after the 24th-power term.
	function automatic u64_t exp_neg_q30(input u64_t f);
		longint sum_v;
		u64_t   term;
		sum_v = longint'(Q30);
		term  = Q30;
		for (int n = 1; n <= 24; n++) begin
			term = udiv((term * f) >> 30, u64_t'(n));
			if (n % 2 == 1)
				sum_v = sum_v - longint'(term);
			else
				sum_v = sum_v + longint'(term);
		end
		if (sum_v < 0)
			sum_v = 0;
		return u64_t'(sum_v);
	endfunction

	function automatic logi_tab_t build_tab();
		logi_tab_t tab;
		u64_t      einv;
		u64_t      tq;
		u64_t      whole;
		u64_t      e;
		u64_t      den;
		einv = exp_neg_q30(Q30);
		for (int i = 0; i < int'(ENTRIES); i++) begin
			tq    = udiv(u64_t'(i) << 34, u64_t'(ENTRIES));
			whole = tq >> 30;
			e     = exp_neg_q30(tq & (Q30 - 64'd1));
			for (longint unsigned k = 0; k < whole; k++)
				e = (e * einv) >> 30;
			den    = Q30 + e;
			tab[i] = VAL_W'(udiv((64'd1 << (FRAC_BITS + 30)) + (den >> 1), den));
		end
		return tab;
	endfunction

	localparam logi_tab_t LOGI_TAB = build_tab();

	always_ff @(posedge clk) begin
		if ({1'b0, addr} < (AW + 1)'(ENTRIES))
			data <= LOGI_TAB[addr];
		else
			data <= '0;
	end

endmodule
`default_nettype wire

>>> rtl/tcql_seq.sv
// Trial sequencer: value table, operand selection for the shared multiplier and result register.
`timescale 1ns / 1ps
`default_nettype none
module tcql_seq
	import tcql_pkg::*;
#(
	parameter int unsigned ENTRIES = LOGI_ENTRIES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cfg_t                       cfg,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [S_DATA_W-1:0]        s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [M_DATA_W-1:0]             m_tdata,
	output logic signed [MUL_A_W-1:0]       mul_a,
	output logic signed [MUL_B_W-1:0]       mul_b,
	input  wire logic signed [MUL_P_W-1:0]  mul_p,
	output logic [$clog2(ENTRIES)-1:0]      rom_addr,
	input  wire logic [VAL_W-1:0]           rom_data
);

	localparam int AW   = $clog2(ENTRIES);
	localparam int HI_W = MUL_P_W - IDX_SHIFT;
	localparam int CF_W = VAL_W + 2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MAG, ST_IDX, ST_LOOK, ST_PROB,
		ST_UPC, ST_UPO, ST_FG0, ST_FG1, ST_LAST, ST_DONE
	} state_t;

	function automatic logic [VAL_W-1:0] sat_rate(input logic [RATE_W-1:0] r);
		if (r > RATE_W'(ONE))
			return VAL_W'(ONE);
		return VAL_W'(r);
	endfunction

	// Adds the rounded product / ONE to a value and clamps to [0, ONE].
	function automatic logic [VAL_W-1:0] apply_step(input logic [VAL_W-1:0] v,
			input logic signed [MUL_P_W-1:0] p);
		logic signed [MUL_P_W-1:0] rs;
		logic signed [CF_W-1:0]    nv;
		rs = (p + MUL_P_W'(HALF)) >>> FRAC_BITS;
		nv = $signed({2'b00, v}) + CF_W'(rs);
		if (nv < 0)
			return '0;
		if (nv > CF_W'(ONE))
			return VAL_W'(ONE);
		return nv[VAL_W-1:0];
	endfunction

	state_t            state_q;
	logic [VAL_W-1:0]  tab_q [4];
	logic              flag_q;
	logic              out_valid_q;
	logic              run_q;

	logic              stim_q, resp_q, ok_q;
	logic [VAL_W-1:0]  snap_q [4];
	logic [VAL_W-1:0]  vc_q, vo_q, vf0_q, vf1_q;
	logic              neg_q, rng_q, gate_q;
	logic [VAL_W-1:0]  prob_q, rate_q;
	logic signed [ERR_W-1:0] pe_c_q, pe_o_q;
	logic [M_DATA_W-1:0] out_q;

	logic              accept;
	logic              out_free;
	logic              out_load;
	logic [VAL_W-1:0]  row0_c, row0_o, row1_c, row1_o, vc_n, vo_n, vf0_n, vf1_n;
	logic signed [ERR_W-1:0] d_val, abs_d;
	logic [TEMP_W-1:0] beta;
	logic [HI_W-1:0]   idx_hi;
	logic [VAL_W-1:0]  lval, prob_n, rate_n;
	logic signed [CF_W-1:0] conf, limit_x;
	logic              gate_n;
	logic              wr_en;
	logic [1:0]        wr_idx;
	logic [VAL_W-1:0]  wr_val;
	logic [VAL_W-1:0]  tgt;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = run_q && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == ST_LAST || state_q == ST_DONE) && out_free;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// Entries of the shown row by role, and of the row not shown by column.
	assign row0_c = resp_q ? tab_q[1] : tab_q[0];
	assign row0_o = resp_q ? tab_q[0] : tab_q[1];
	assign row1_c = resp_q ? tab_q[3] : tab_q[2];
	assign row1_o = resp_q ? tab_q[2] : tab_q[3];
	assign vc_n   = stim_q ? row1_c : row0_c;
	assign vo_n   = stim_q ? row1_o : row0_o;
	assign vf0_n  = stim_q ? tab_q[0] : tab_q[2];
	assign vf1_n  = stim_q ? tab_q[1] : tab_q[3];

	assign d_val  = $signed({1'b0, vc_n}) - $signed({1'b0, vo_n});
	assign abs_d  = d_val[ERR_W-1] ? -d_val : d_val;
	assign beta   = flag_q ? cfg.temp_low_conflict : cfg.temp_base;
	assign tgt    = ok_q ? VAL_W'(ONE) : '0;

	assign idx_hi   = mul_p[MUL_P_W-1:IDX_SHIFT];
	assign rom_addr = idx_hi[AW-1:0];

	assign lval    = rng_q ? rom_data : VAL_W'(ONE);
	assign prob_n  = neg_q ? VAL_W'(ONE) - lval : lval;
	assign conf    = $signed({1'b0, prob_n, 1'b0}) - $signed(CF_W'(ONE));
	assign limit_x = CF_W'(cfg.conflict_limit);
	assign gate_n  = ok_q ? (conf < limit_x) : (-conf < limit_x);

	always_comb begin
		rate_n = sat_rate(cfg.rate_base);
		if (cfg.mode_bits[MODE_ERR_RATE] && !ok_q)
			rate_n = sat_rate(cfg.rate_on_error);
		if (cfg.mode_bits[MODE_GATE_RATE] && gate_n)
			rate_n = sat_rate(cfg.rate_low_conflict);
	end

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		wr_en  = 1'b0;
		wr_idx = {stim_q, resp_q};
		wr_val = apply_step(vc_q, mul_p);
		unique case (state_q)
			ST_MAG: begin
				mul_a = MUL_A_W'(abs_d);
				mul_b = $signed(MUL_B_W'(beta));
			end
			ST_IDX: begin
				mul_a = MUL_A_W'(mul_p);
				mul_b = $signed(MUL_B_W'(ENTRIES));
			end
			ST_UPC: begin
				mul_a = $signed(MUL_A_W'(rate_q));
				mul_b = MUL_B_W'(pe_c_q);
			end
			ST_UPO: begin
				wr_en = 1'b1;
				mul_a = $signed(MUL_A_W'(rate_q));
				mul_b = MUL_B_W'(pe_o_q);
			end
			ST_FG0: begin
				wr_en  = 1'b1;
				wr_idx = {stim_q, !resp_q};
				wr_val = apply_step(vo_q, mul_p);
				mul_a  = $signed(MUL_A_W'(sat_rate(cfg.forget_rate)));
				mul_b  = MUL_B_W'($signed(ERR_W'(HALF)) - $signed({1'b0, vf0_q}));
			end
			ST_FG1: begin
				wr_en  = 1'b1;
				wr_idx = {!stim_q, 1'b0};
				wr_val = apply_step(vf0_q, mul_p);
				mul_a  = $signed(MUL_A_W'(sat_rate(cfg.forget_rate)));
				mul_b  = MUL_B_W'($signed(ERR_W'(HALF)) - $signed({1'b0, vf1_q}));
			end
			ST_LAST: begin
				wr_en  = 1'b1;
				wr_idx = {!stim_q, 1'b1};
				wr_val = apply_step(vf1_q, mul_p);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
			run_q       <= 1'b0;
			for (int k = 0; k < 4; k++)
				tab_q[k] <= VAL_W'(HALF);
		end else begin
			run_q <= 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready)
				out_valid_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				if (wr_en && wr_idx == 2'(k))
					tab_q[k] <= wr_val;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MAG;
						if (s_tdata[3]) begin
							flag_q <= 1'b0;
							for (int k = 0; k < 4; k++)
								tab_q[k] <= VAL_W'(HALF);
						end
					end
				end
				ST_MAG:  state_q <= ST_IDX;
				ST_IDX:  state_q <= ST_LOOK;
				ST_LOOK: state_q <= ST_PROB;
				ST_PROB: state_q <= ST_UPC;
				ST_UPC:  state_q <= ST_UPO;
				ST_UPO:  state_q <= ST_FG0;
				ST_FG0:  state_q <= ST_FG1;
				ST_FG1:  state_q <= ST_LAST;
				ST_LAST: begin
					flag_q <= cfg.mode_bits[MODE_GATE_TEMP] ? gate_q : 1'b0;
					if (out_free)
						state_q <= ST_IDLE;
					else
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stim_q <= s_tdata[0];
			resp_q <= s_tdata[1];
			ok_q   <= s_tdata[2];
		end
		if (state_q == ST_MAG) begin
			for (int k = 0; k < 4; k++)
				snap_q[k] <= tab_q[k];
			vc_q   <= vc_n;
			vo_q   <= vo_n;
			vf0_q  <= vf0_n;
			vf1_q  <= vf1_n;
			neg_q  <= d_val[ERR_W-1];
			pe_c_q <= $signed({1'b0, tgt}) - $signed({1'b0, vc_n});
			pe_o_q <= $signed(ERR_W'(ONE)) - $signed({1'b0, tgt}) - $signed({1'b0, vo_n});
		end
		if (state_q == ST_LOOK)
			rng_q <= (idx_hi < HI_W'(ENTRIES));
		if (state_q == ST_PROB) begin
			prob_q <= prob_n;
			gate_q <= gate_n;
			rate_q <= rate_n;
		end
		if (out_load)
			out_q <= {(M_DATA_W - OUT_BITS)'(0), pe_o_q, pe_c_q,
				snap_q[3], snap_q[2], snap_q[1], snap_q[0], prob_q};
	end

endmodule
`default_nettype wire

>>> rtl/two_choice_q_learning_trial.sv
// Top level of the two-choice Q-learning trial block.
//
//  Channel  Direction  Beat contents
//  s_*      in         one trial: stimulus, response, correct, restart
//  m_*      out        choice_prob, value table before update, both prediction errors
//  cfg_*    in         register write, index 0 to 7, no read-back
//
// A trial steps the sequencer through ST_MAG, ST_IDX, ST_LOOK, ST_PROB, ST_UPC, ST_UPO,
// ST_FG0, ST_FG1 and ST_LAST, then loads the result beat; no new trial is accepted before
// it is back in ST_IDLE, and the chain of dependent products through the one shared
// multiplier and the registered logistic table sets this. s_tready is high only while the
// sequencer is idle; a finished result waits in the output register while the next trial
// is accepted, and a stalled m_tready delays only the final step. Reset sets the value table
// to one half and the temperature flag to zero; s_tready rises on the edge after reset ends.
`timescale 1ns / 1ps
`default_nettype none
module two_choice_q_learning_trial
	import tcql_pkg::*;
#(
	parameter int unsigned LOGISTIC_ENTRIES = LOGI_ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// stimulus, response, correct, restart, zero fill
	input  wire logic [S_DATA_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// choice_prob, value_00, value_01, value_10, value_11, error_chosen, error_other, zero fill
	output logic [M_DATA_W-1:0]        m_tdata,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(LOGISTIC_ENTRIES);

	cfg_t                      cfg;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic [AW-1:0]             rom_addr;
	logic [VAL_W-1:0]          rom_data;

	tcql_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	tcql_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	tcql_logi_rom #(
		.ENTRIES (LOGISTIC_ENTRIES)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	tcql_seq #(
		.ENTRIES (LOGISTIC_ENTRIES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.mul_a    (mul_a),
		.mul_b    (mul_b),
		.mul_p    (mul_p),
		.rom_addr (rom_addr),
		.rom_data (rom_data)
	);

endmodule
`default_nettype wire
